// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, clocked on clk with asynchronous reset off.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/dtmf_spc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmf_spc_pkg
// Shared types and constants of the DTMF spectral peak classifier.
// ----------------------------------------------------------------------------
package dtmf_spc_pkg;

	localparam int STEP_W = 12;
	localparam int TOL_W  = 10;
	localparam int EDGE_W = 16;
	localparam int BIN_W  = 32;
	localparam int SYM_W  = 5;
	localparam int TONE_W = 12;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 16;

	typedef enum logic [CFG_AW-1:0] {
		REG_BIN_STEP   = 3'd0,
		REG_TOLERANCE  = 3'd1,
		REG_HIGH_LOWER = 3'd2,
		REG_HIGH_UPPER = 3'd3,
		REG_LOW_LOWER  = 3'd4,
		REG_LOW_UPPER  = 3'd5
	} cfg_reg_t;

	localparam logic [STEP_W-1:0] RST_BIN_STEP   = 12'd49;
	localparam logic [TOL_W-1:0]  RST_TOLERANCE  = 10'd50;
	localparam logic [EDGE_W-1:0] RST_HIGH_LOWER = 16'd2200;
	localparam logic [EDGE_W-1:0] RST_HIGH_UPPER = 16'd3400;
	localparam logic [EDGE_W-1:0] RST_LOW_LOWER  = 16'd1200;
	localparam logic [EDGE_W-1:0] RST_LOW_UPPER  = 16'd2000;

	localparam logic [SYM_W-1:0] SYM_GAP  = 5'd16;
	localparam logic [SYM_W-1:0] SYM_NONE = 5'd17;

	typedef logic [TONE_W-1:0] tone_arr_t [4];

	// tone frequencies in half hertz
	localparam tone_arr_t COL_TONE = '{12'd2418, 12'd2672, 12'd2954, 12'd3266};
	localparam tone_arr_t ROW_TONE = '{12'd1394, 12'd1540, 12'd1704, 12'd1882};

endpackage

// ===== design/dtmf_spectral_peak_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmf_spectral_peak_classifier
// Tracks the strongest bin in the row and column bands over a spectrum frame
// and classifies the peak pair as a keypad symbol, a gap or the held symbol at each frame end.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  s_axis   | in  | tvalid/tready          | tdata[31:0] bin_value, tlast frame_end
//  m_axis   | out | tvalid/tready          | tdata[4:0] symbol_code
//  cfg      | in  | cfg_valid/cfg_ready    | cfg_addr register index, cfg_data
//
// One bin per cycle sustained unless a stalled output stops the input; the 32x32
// square in stage 2 sets the clock. Frame-end symbols pass stages 3 and 4 to the output.
// Reset clears counter, peaks, held symbol (none yet) and all valid flags.
// A stalled output backs up only at frame ends: three symbols can wait in the
// output, stage 4 and stage 3; a fourth frame-end beat then holds in stage 2
// and stops the input behind it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtmf_spectral_peak_classifier #(
	parameter int MAX_BINS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [dtmf_spc_pkg::BIN_W-1:0]    s_axis_tdata,  // [31:0] bin_value
	input  logic                              s_axis_tlast,  // frame_end
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [7:0]                        m_axis_tdata,  // [4:0] symbol_code
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dtmf_spc_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [dtmf_spc_pkg::CFG_DW-1:0]   cfg_data
);
	import dtmf_spc_pkg::*;

	localparam int IDX_W = $clog2(MAX_BINS);
	localparam int CNT_W = $clog2(MAX_BINS + 1);
	localparam int F_W   = IDX_W + STEP_W;
	localparam int CMP_W = F_W + 1;

	// configuration
	logic [STEP_W-1:0] step_q;
	logic [TOL_W-1:0]  tol_q;
	logic [EDGE_W-1:0] hbl_q, hbu_q, lbl_q, lbu_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= RST_BIN_STEP;
			tol_q  <= RST_TOLERANCE;
			hbl_q  <= RST_HIGH_LOWER;
			hbu_q  <= RST_HIGH_UPPER;
			lbl_q  <= RST_LOW_LOWER;
			lbu_q  <= RST_LOW_UPPER;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_BIN_STEP:   step_q <= cfg_data[STEP_W-1:0];
				REG_TOLERANCE:  tol_q  <= cfg_data[TOL_W-1:0];
				REG_HIGH_LOWER: hbl_q  <= cfg_data;
				REG_HIGH_UPPER: hbu_q  <= cfg_data;
				REG_LOW_LOWER:  lbl_q  <= cfg_data;
				REG_LOW_UPPER:  lbu_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage handshake
	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic last_s1, last_s2;
	logic s1_ready, s2_ready, s3_ready, s4_ready, s2_fire;

	assign s4_ready = !out_valid_q || m_axis_tready;
	assign s3_ready = !valid_s3 || s4_ready;
	assign s2_ready = !valid_s2 || !last_s2 || s3_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign s2_fire  = valid_s2 && (!last_s2 || s3_ready);
	assign s_axis_tready = s1_ready;

	logic in_beat;
	assign in_beat = s_axis_tvalid && s1_ready;

	// bin counter, saturates at MAX_BINS
	logic [CNT_W-1:0] cnt_q;
	logic             cnt_in_range;
	assign cnt_in_range = cnt_q < CNT_W'(MAX_BINS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_beat) begin
			if (s_axis_tlast)
				cnt_q <= '0;
			else if (cnt_in_range)
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// stage 1: input register
	logic [BIN_W-1:0] bin_s1;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	logic             inr_s1, inr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			bin_s1  <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
			idx_s1  <= cnt_q[IDX_W-1:0];
			inr_s1  <= cnt_in_range;
		end
	end

	// stage 2: power and bin frequency
	logic [BIN_W-1:0]   mag;
	logic [2*BIN_W-1:0] pw_s2;
	logic [F_W-1:0]     f_s2;

	// two's complement negate also maps the most negative value onto 2^31
	assign mag = bin_s1[BIN_W-1] ? (~bin_s1 + BIN_W'(1)) : bin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s2_ready) begin
			pw_s2   <= (2*BIN_W)'(mag) * (2*BIN_W)'(mag);
			f_s2    <= F_W'(idx_s1) * F_W'(step_q);
			idx_s2  <= idx_s1;
			inr_s2  <= inr_s1;
			last_s2 <= last_s1;
		end
	end

	// running peaks
	logic [2*BIN_W-1:0] hi_pow_q, lo_pow_q, hi_pow_nx, lo_pow_nx;
	logic [IDX_W-1:0]   hi_idx_q, lo_idx_q, hi_idx_nx, lo_idx_nx;
	logic               hi_take, lo_take;

	assign hi_take = inr_s2 && (pw_s2 > hi_pow_q)
		&& (f_s2 > F_W'(hbl_q)) && (f_s2 < F_W'(hbu_q));
	assign lo_take = inr_s2 && (pw_s2 > lo_pow_q)
		&& (f_s2 > F_W'(lbl_q)) && (f_s2 < F_W'(lbu_q));
	assign hi_pow_nx = hi_take ? pw_s2 : hi_pow_q;
	assign hi_idx_nx = hi_take ? idx_s2 : hi_idx_q;
	assign lo_pow_nx = lo_take ? pw_s2 : lo_pow_q;
	assign lo_idx_nx = lo_take ? idx_s2 : lo_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_pow_q <= '0;
			lo_pow_q <= '0;
		end else if (s2_fire) begin
			hi_pow_q <= last_s2 ? '0 : hi_pow_nx;
			lo_pow_q <= last_s2 ? '0 : lo_pow_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			hi_idx_q <= hi_idx_nx;
			lo_idx_q <= lo_idx_nx;
		end
	end

	// stage 3: frame-end snapshot of the peaks
	logic [IDX_W-1:0] hi_idx_s3, lo_idx_s3;
	logic             hi_ok_s3, lo_ok_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_ready) begin
			valid_s3 <= s2_fire && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire && last_s2) begin
			hi_idx_s3 <= hi_idx_nx;
			lo_idx_s3 <= lo_idx_nx;
			hi_ok_s3  <= hi_pow_nx != '0;
			lo_ok_s3  <= lo_pow_nx != '0;
		end
	end

	// stage 4: peak frequencies
	logic [F_W-1:0] fh_s4, fl_s4;
	logic           hi_ok_s4, lo_ok_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (s4_ready) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && s4_ready) begin
			fh_s4    <= F_W'(hi_idx_s3) * F_W'(step_q);
			fl_s4    <= F_W'(lo_idx_s3) * F_W'(step_q);
			hi_ok_s4 <= hi_ok_s3;
			lo_ok_s4 <= lo_ok_s3;
		end
	end

	// tone match and symbol decision
	logic [3:0]       col_m, row_m;
	logic             col_hit, row_hit;
	logic [1:0]       col_sel, row_sel;
	logic [SYM_W-1:0] sym_nx, held_q, out_sym_q;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			col_m[k] = hi_ok_s4
				&& (CMP_W'(fh_s4) + CMP_W'(tol_q) > CMP_W'(COL_TONE[k]))
				&& (CMP_W'(fh_s4) < CMP_W'(COL_TONE[k]) + CMP_W'(tol_q));
			row_m[k] = lo_ok_s4
				&& (CMP_W'(fl_s4) + CMP_W'(tol_q) > CMP_W'(ROW_TONE[k]))
				&& (CMP_W'(fl_s4) < CMP_W'(ROW_TONE[k]) + CMP_W'(tol_q));
		end
	end

	// first column wins, last row wins; selects only matter on a hit
	always_comb begin
		priority if (col_m[0]) col_sel = 2'd0;
		else if (col_m[1])     col_sel = 2'd1;
		else if (col_m[2])     col_sel = 2'd2;
		else                   col_sel = 2'd3;
		priority if (row_m[3]) row_sel = 2'd3;
		else if (row_m[2])     row_sel = 2'd2;
		else if (row_m[1])     row_sel = 2'd1;
		else                   row_sel = 2'd0;
	end

	assign col_hit = |col_m;
	assign row_hit = |row_m;

	always_comb begin
		priority if (!col_hit) sym_nx = SYM_GAP;
		else if (row_hit)      sym_nx = {1'b0, row_sel, col_sel};
		else                   sym_nx = held_q;
	end

	// output register and held symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_q      <= SYM_NONE;
		end else if (valid_s4 && s4_ready) begin
			out_valid_q <= 1'b1;
			held_q      <= sym_nx;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4 && s4_ready)
			out_sym_q <= sym_nx;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_sym_q};

	`ASSERT_IMP(a_sym_range, clk, arst_n, m_axis_tvalid, out_sym_q <= SYM_NONE)
	`ASSERT_IMP(a_held_range, clk, arst_n, 1'b1, held_q <= SYM_NONE)
	`ASSERT_IMP(a_cnt_sat, clk, arst_n, 1'b1, cnt_q <= CNT_W'(MAX_BINS))
	`ASSERT_NXT(a_cnt_clear, clk, arst_n, in_beat && s_axis_tlast, cnt_q == '0)
	`ASSERT_NXT(a_peak_clear, clk, arst_n, s2_fire && last_s2, hi_pow_q == '0 && lo_pow_q == '0)
	`ASSERT_NXT(a_out_load, clk, arst_n, valid_s4 && s4_ready, out_valid_q && held_q == out_sym_q)

endmodule
